>>> rtl/atrp_pkg.sv
// Shared types and constants for the AT response parser.
package atrp_pkg;

  // Size of the external line store.
  localparam int MAX_LINES = 8;
  localparam int LINE_LEN  = 64;

  // The column counter saturates at LINE_LEN, so it must be able to hold it.
  localparam int COL_W = $clog2(LINE_LEN + 1);

  // Byte codes recognized by the parser.
  localparam logic [7:0] CHAR_CR    = 8'h0D;
  localparam logic [7:0] CHAR_LF    = 8'h0A;
  localparam logic [7:0] CHAR_SPACE = 8'h20;
  localparam logic [7:0] CHAR_TILDE = 8'h7E;
  localparam logic [7:0] CHAR_PLUS  = 8'h2B;
  localparam logic [7:0] CHAR_E     = 8'h45;
  localparam logic [7:0] CHAR_O     = 8'h4F;
  localparam logic [7:0] CHAR_K     = 8'h4B;
  localparam logic [7:0] CHAR_R     = 8'h52;

  // Status codes reported with every item.
  typedef enum logic [1:0] {
    STATUS_NOT_READY = 2'd0,
    STATUS_DONE      = 2'd1,
    STATUS_ERROR     = 2'd2
  } status_t;

  // Parse states; the codes are fixed by the response grammar.
  typedef enum logic [4:0] {
    PS_WAIT_CR      = 5'd0,
    PS_WAIT_LF      = 5'd1,
    PS_FIRST        = 5'd2,
    PS_LINE_START   = 5'd3,
    PS_LINE_BODY    = 5'd4,
    PS_LINE_LF      = 5'd5,
    PS_NEXT_LINE    = 5'd6,
    PS_FINAL_LF     = 5'd7,
    PS_FINAL_WORD   = 5'd8,
    PS_ERR_R1       = 5'd9,
    PS_ERR_R2       = 5'd10,
    PS_ERR_O        = 5'd11,
    PS_ERR_R3       = 5'd12,
    PS_ERR_CR       = 5'd13,
    PS_ERR_TRAIL    = 5'd14,
    PS_OK_K         = 5'd16,
    PS_OK_CR        = 5'd17,
    PS_OK_TRAIL     = 5'd18
  } parse_state_t;

  // Parser state carried from item to item.
  typedef struct packed {
    parse_state_t      parse_state;
    logic [7:0]        line_total;
    logic [COL_W-1:0]  column;
    logic              final_kind;
  } parser_state_t;

  // One result item.
  typedef struct packed {
    status_t     status;
    logic [7:0]  lines_done;
    logic        ended_with_error;
    logic        store_write;
    logic [2:0]  store_line;
    logic [5:0]  store_col;
    logic [7:0]  store_byte;
  } result_t;

endpackage

>>> rtl/at_response_parser_top.sv
// Top level of the AT response parser: input register, parser state and result register.
//
// The parser checks the bytes of a modem AT response, one byte per item on
// the input channel (in_valid/in_ready, fields in_byte and expect_final).
// For every byte it returns exactly one result item on the output channel
// (out_valid/out_ready): a status (not ready, complete, syntax error), the
// count of finished text lines, the final word kind, and an optional write
// of a text byte or line terminator to an external line store.
//
// The byte is captured in the input register at the accepting edge; then one
// pass of parser logic updates the state and loads the result register.
// Throughput is one item per cycle while the receiver keeps out_ready high;
// a stall holds the result register and then the input register.
//
// When the receiver stalls, the result register holds its item and the
// input register fills; in_ready drops only while both are occupied, and
// rises in the same cycle that out_ready frees the result register.
// Reset clears both registers and returns the parser to waiting for the
// opening CR with zero line count, column and final kind.
module at_response_parser_top
  import atrp_pkg::*;
(
  input  logic       clk,
  input  logic       rst,
  input  logic       in_valid,
  output logic       in_ready,
  input  logic [7:0] in_byte,
  input  logic       expect_final,
  output logic       out_valid,
  input  logic       out_ready,
  output logic [1:0] status,
  output logic [7:0] lines_done,
  output logic       ended_with_error,
  output logic       store_write,
  output logic [2:0] store_line,
  output logic [5:0] store_col,
  output logic [7:0] store_byte
);

  logic          in_full;
  logic [7:0]    byte_q;
  logic          expect_q;
  logic          step_fire;
  logic          in_take;
  parser_state_t state;
  parser_state_t state_next;
  result_t       result_next;
  result_t       result;

  // Handshake: the held byte is parsed whenever the result register can take it.
  assign step_fire = in_full && (!out_valid || out_ready);
  assign in_ready  = !in_full || step_fire;
  assign in_take   = in_valid && in_ready;

  // Input register.
  always_ff @(posedge clk) begin
    if (rst) begin
      in_full <= 1'b0;
    end else begin
      in_full <= in_take || (in_full && !step_fire);
    end
    if (in_take) begin
      byte_q   <= in_byte;
      expect_q <= expect_final;
    end
  end

  atrp_step u_step (
    .state        (state),
    .in_byte      (byte_q),
    .expect_final (expect_q),
    .state_next   (state_next),
    .result       (result_next)
  );

  // Parser state advances once per parsed byte.
  always_ff @(posedge clk) begin
    if (rst) begin
      state.parse_state <= PS_WAIT_CR;
      state.line_total  <= 8'd0;
      state.column      <= '0;
      state.final_kind  <= 1'b0;
    end else if (step_fire) begin
      state <= state_next;
    end
  end

  // Result register.
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else begin
      out_valid <= step_fire || (out_valid && !out_ready);
    end
    if (step_fire) begin
      result <= result_next;
    end
  end

  assign status           = result.status;
  assign lines_done       = result.lines_done;
  assign ended_with_error = result.ended_with_error;
  assign store_write      = result.store_write;
  assign store_line       = result.store_line;
  assign store_col        = result.store_col;
  assign store_byte       = result.store_byte;

  // A line store write only happens on a byte that was accepted into a line.
  assert property (@(posedge clk) disable iff (rst)
    out_valid && store_write |-> status == STATUS_NOT_READY)
    else $error("store write reported with a completion or error status");

  // The final word kind is only reported on a completed response.
  assert property (@(posedge clk) disable iff (rst)
    out_valid && ended_with_error |-> status == STATUS_DONE)
    else $error("final word kind reported without completion");

  // A syntax error leaves the parser state untouched.
  assert property (@(posedge clk) disable iff (rst)
    step_fire && result_next.status == STATUS_ERROR |=> $stable(state))
    else $error("parser state changed on a syntax error");

  // The line store index never reaches the last line.
  assert property (@(posedge clk) disable iff (rst)
    out_valid && store_write |-> 32'(store_line) < 32'(MAX_LINES - 1))
    else $error("line store write beyond the last usable line");

endmodule

>>> rtl/atrp_step.sv
// Next-state and result logic of the AT response parser for one byte.
module atrp_step
  import atrp_pkg::*;
(
  input  parser_state_t state,
  input  logic [7:0]    in_byte,
  input  logic          expect_final,
  output parser_state_t state_next,
  output result_t       result
);

  logic       printable;
  logic       store_req;
  logic       store_ok;
  logic [7:0] store_data;
  status_t    status;

  assign printable = (in_byte >= CHAR_SPACE) && (in_byte <= CHAR_TILDE);

  // Writes go out only while the line index and column are inside the store.
  assign store_ok = (32'(state.line_total) < 32'(MAX_LINES - 1)) &&
                    (32'(state.column) <= 32'(LINE_LEN - 1));

  // Transition of the response grammar; an error keeps every state field.
  always_comb begin
    state_next = state;
    status     = STATUS_NOT_READY;
    store_req  = 1'b0;
    store_data = 8'h00;
    unique case (state.parse_state)
      PS_WAIT_CR: begin
        if (in_byte == CHAR_CR) begin
          state_next.line_total  = 8'd0;
          state_next.parse_state = PS_WAIT_LF;
        end else begin
          status = STATUS_ERROR;
        end
      end
      PS_WAIT_LF: begin
        if (in_byte == CHAR_LF) state_next.parse_state = PS_FIRST;
        else status = STATUS_ERROR;
      end
      PS_FIRST: begin
        if (expect_final) begin
          if (in_byte == CHAR_PLUS) state_next.parse_state = PS_LINE_START;
          else if (in_byte == CHAR_E) state_next.parse_state = PS_ERR_R1;
          else if (in_byte == CHAR_O) state_next.parse_state = PS_OK_K;
          else status = STATUS_ERROR;
        end else begin
          state_next.parse_state = PS_LINE_START;
        end
      end
      PS_LINE_START, PS_LINE_BODY: begin
        if (printable) begin
          store_req  = 1'b1;
          store_data = in_byte;
          if (32'(state.column) < 32'(LINE_LEN)) begin
            state_next.column = state.column + COL_W'(1);
          end
          state_next.parse_state = PS_LINE_BODY;
        end else if (state.parse_state == PS_LINE_BODY && in_byte == CHAR_CR) begin
          // End of a text line: write the terminator and count the line.
          store_req = 1'b1;
          if (state.line_total != 8'hFF) begin
            state_next.line_total = state.line_total + 8'd1;
          end
          state_next.column      = '0;
          state_next.parse_state = PS_LINE_LF;
        end else begin
          status = STATUS_ERROR;
        end
      end
      PS_LINE_LF: begin
        if (in_byte == CHAR_LF) state_next.parse_state = PS_NEXT_LINE;
        else status = STATUS_ERROR;
      end
      PS_NEXT_LINE: begin
        if (in_byte == CHAR_CR) state_next.parse_state = PS_FINAL_LF;
        else if (in_byte == CHAR_PLUS) state_next.parse_state = PS_LINE_START;
        else status = STATUS_ERROR;
      end
      PS_FINAL_LF: begin
        if (in_byte == CHAR_LF) state_next.parse_state = PS_FINAL_WORD;
        else status = STATUS_ERROR;
      end
      PS_FINAL_WORD: begin
        if (in_byte == CHAR_O) state_next.parse_state = PS_OK_K;
        else if (in_byte == CHAR_E) state_next.parse_state = PS_ERR_R1;
        else status = STATUS_ERROR;
      end
      PS_ERR_R1: begin
        if (in_byte == CHAR_R) state_next.parse_state = PS_ERR_R2;
        else status = STATUS_ERROR;
      end
      PS_ERR_R2: begin
        if (in_byte == CHAR_R) state_next.parse_state = PS_ERR_O;
        else status = STATUS_ERROR;
      end
      PS_ERR_O: begin
        if (in_byte == CHAR_O) state_next.parse_state = PS_ERR_R3;
        else status = STATUS_ERROR;
      end
      PS_ERR_R3: begin
        if (in_byte == CHAR_R) state_next.parse_state = PS_ERR_CR;
        else status = STATUS_ERROR;
      end
      PS_ERR_CR: begin
        if (in_byte == CHAR_CR) state_next.parse_state = PS_ERR_TRAIL;
        else status = STATUS_ERROR;
      end
      PS_ERR_TRAIL: begin
        // Any trailing byte completes a response that ended in ERROR.
        state_next.final_kind  = 1'b1;
        state_next.parse_state = PS_WAIT_CR;
        status                 = STATUS_DONE;
      end
      PS_OK_K: begin
        if (in_byte == CHAR_K) state_next.parse_state = PS_OK_CR;
        else status = STATUS_ERROR;
      end
      PS_OK_CR: begin
        if (in_byte == CHAR_CR) state_next.parse_state = PS_OK_TRAIL;
        else status = STATUS_ERROR;
      end
      PS_OK_TRAIL: begin
        state_next.final_kind  = 1'b0;
        state_next.parse_state = PS_WAIT_CR;
        status                 = STATUS_DONE;
      end
      default: begin
        status = STATUS_ERROR;
      end
    endcase
  end

  // Assemble the result item; store fields are zero when nothing is written.
  always_comb begin
    result                  = '0;
    result.status           = status;
    result.lines_done       = state_next.line_total;
    result.ended_with_error = (status == STATUS_DONE) ? state_next.final_kind : 1'b0;
    if (store_req && store_ok) begin
      result.store_write = 1'b1;
      result.store_line  = state.line_total[2:0];
      result.store_col   = 6'(state.column);
      result.store_byte  = store_data;
    end
  end

endmodule
